FILE: design/ppls_pkg.sv
// Shared types and constants for the PID position loop with settle detection.
// Holds the word layouts of both channels, the register file and the stage words.
// No dependencies.
`timescale 1ns / 1ps

package ppls_pkg;

	// Field widths
	localparam int AngleW   = 20;
	localparam int ErrW     = AngleW + 1;
	localparam int DiffW    = ErrW + 1;
	localparam int SumW     = 32;
	localparam int GainW    = 24;
	localparam int LimW     = 31;
	localparam int ThrW     = 20;
	localparam int CntW     = 16;
	localparam int ForceW   = 32;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 31;
	localparam int FracW    = 16;

	// Product and accumulator widths (gains are zero-extended to signed)
	localparam int PProdW = GainW + 1 + ErrW;
	localparam int IProdW = GainW + 1 + SumW;
	localparam int DProdW = GainW + 1 + DiffW;
	localparam int AccW   = IProdW + 1;
	localparam int ShW    = AccW - FracW;

	// Opcodes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STOP  = 2'd2;

	// Register indexes
	localparam logic [CfgIdxW-1:0] REG_PROP_GAIN    = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_INTEG_GAIN   = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_DERIV_GAIN   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_SUM_LIMIT    = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_FORCE_LIMIT  = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_SETTLE_THR   = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_SETTLE_TICKS = 3'd6;

	localparam logic [LimW-1:0] SUM_LIMIT_RESET = 31'h7FFF_FFFF;

	// Input word
	typedef struct packed {
		logic [1:0]               opcode;
		logic signed [AngleW-1:0] target_angle;
		logic signed [AngleW-1:0] measured_angle;
	} item_word_t;

	// Result word
	typedef struct packed {
		logic signed [ForceW-1:0] force_res;
		logic                     in_band;
		logic                     settled_event;
		logic                     active;
	} result_word_t;

	// Register file
	typedef struct packed {
		logic [GainW-1:0] prop_gain;
		logic [GainW-1:0] integ_gain;
		logic [GainW-1:0] deriv_gain;
		logic [LimW-1:0]  error_sum_limit;
		logic [LimW-1:0]  force_limit;
		logic [ThrW-1:0]  settle_threshold;
		logic [CntW-1:0]  settle_ticks;
	} cfg_regs_t;

	// Control stage output: terms for the multipliers plus flags
	typedef struct packed {
		logic                   run;
		logic signed [ErrW-1:0] err;
		logic signed [SumW-1:0] error_sum;
		logic signed [DiffW-1:0] diff;
		logic                   in_band;
		logic                   settled_event;
		logic                   active;
	} ctrl_word_t;

	// Product stage output
	typedef struct packed {
		logic                     run;
		logic signed [PProdW-1:0] p_prod;
		logic signed [IProdW-1:0] i_prod;
		logic signed [DProdW-1:0] d_prod;
		logic                     in_band;
		logic                     settled_event;
		logic                     active;
	} prod_word_t;

endpackage

FILE: design/ppls_ctrl.sv
// Control stage of the PID loop: error, clamped error sum, derivative term,
// band check, settle counter and one-shot event state.
// Depends on ppls_pkg.
`timescale 1ns / 1ps

module ppls_ctrl
	import ppls_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic       item_vld,
	input  item_word_t item_w,
	input  cfg_regs_t  cfg,
	output ctrl_word_t ctrl_s2
);

	logic signed [SumW-1:0] error_sum_q;
	logic signed [ErrW-1:0] last_error_q;
	logic [CntW-1:0]        in_band_count_q;
	logic                   pending_q;
	logic                   running_q;

	logic signed [ErrW-1:0]  err;
	logic                    is_start;
	logic                    is_stop;
	logic                    is_run;
	logic signed [SumW-1:0]  base_sum;
	logic signed [ErrW-1:0]  base_last;
	logic [CntW-1:0]         base_cnt;
	logic                    base_pend;
	logic signed [SumW:0]    sum_wide;
	logic signed [SumW:0]    lim;
	logic signed [SumW:0]    neg_lim;
	logic signed [SumW-1:0]  sum_new;
	logic signed [DiffW-1:0] diff;
	logic [ErrW-1:0]         mag;
	logic                    band;
	logic [CntW-1:0]         cnt_inc;
	logic [CntW-1:0]         cnt_new;
	logic                    settle;
	logic                    evt;
	logic                    pend_new;
	logic                    running_new;
	logic                    take;

	// Error and decode
	always_comb begin
		err      = ErrW'(item_w.target_angle) - ErrW'(item_w.measured_angle);
		is_start = (item_w.opcode == OP_START);
		is_stop  = (item_w.opcode == OP_STOP);
		is_run   = is_start || ((item_w.opcode == OP_TICK) && running_q);
		take     = adv && item_vld;
	end

	// A start clears the move state before the tick runs
	always_comb begin
		base_sum  = is_start ? '0 : error_sum_q;
		base_last = is_start ? err : last_error_q;
		base_cnt  = is_start ? '0 : in_band_count_q;
		base_pend = is_start ? 1'b1 : pending_q;
	end

	// Anti-windup clamp on the running sum
	always_comb begin
		sum_wide = (SumW+1)'(base_sum) + (SumW+1)'(err);
		lim      = $signed({2'b00, cfg.error_sum_limit});
		neg_lim  = -lim;
		if (sum_wide > lim) begin
			sum_new = lim[SumW-1:0];
		end else if (sum_wide < neg_lim) begin
			sum_new = neg_lim[SumW-1:0];
		end else begin
			sum_new = sum_wide[SumW-1:0];
		end
		diff = DiffW'(err) - DiffW'(base_last);
	end

	// Band check and settle counter (saturating)
	always_comb begin
		mag     = err[ErrW-1] ? ErrW'(-err) : ErrW'(err);
		band    = is_run && (mag < {1'b0, cfg.settle_threshold});
		cnt_inc = (base_cnt == {CntW{1'b1}}) ? base_cnt : base_cnt + 1'b1;
		cnt_new = band ? cnt_inc : '0;
		settle  = band && (cnt_inc >= cfg.settle_ticks) && base_pend;
	end

	// Event and run flags after this word
	always_comb begin
		evt         = 1'b0;
		pend_new    = pending_q;
		running_new = running_q;
		if (is_stop) begin
			evt         = pending_q;
			pend_new    = 1'b0;
			running_new = 1'b0;
		end else if (is_run) begin
			evt         = (is_start && pending_q) || settle;
			pend_new    = base_pend && !settle;
			running_new = 1'b1;
		end
	end

	// Loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q     <= '0;
			last_error_q    <= '0;
			in_band_count_q <= '0;
			pending_q       <= 1'b0;
			running_q       <= 1'b0;
		end else if (take) begin
			if (is_run) begin
				error_sum_q     <= sum_new;
				last_error_q    <= err;
				in_band_count_q <= cnt_new;
			end
			pending_q <= pend_new;
			running_q <= running_new;
		end
	end

	// Stage register toward the multipliers
	always_ff @(posedge clk) begin
		if (adv) begin
			ctrl_s2.run           <= is_run;
			ctrl_s2.err           <= err;
			ctrl_s2.error_sum     <= sum_new;
			ctrl_s2.diff          <= diff;
			ctrl_s2.in_band       <= band;
			ctrl_s2.settled_event <= evt;
			ctrl_s2.active        <= running_new;
		end
	end

	// A stop leaves the loop idle with nothing pending
	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && is_stop) |=> (!running_q && !pending_q))
		else $error("stop did not clear running and pending");

	// A start arms the loop and seeds the derivative history
	a_start_seeds: assert property (@(posedge clk) disable iff (!arst_n)
		(take && is_start) |=> (running_q && (last_error_q == $past(err))))
		else $error("start did not seed loop state");

	// The settle event fires once per move
	a_settle_once: assert property (@(posedge clk) disable iff (!arst_n)
		(take && settle) |=> !pending_q)
		else $error("pending still set after settle event");

endmodule

FILE: design/ppls_mult.sv
// Product stage of the PID loop: the three gain-times-term multiplies.
// Depends on ppls_pkg.
`timescale 1ns / 1ps

module ppls_mult
	import ppls_pkg::*;
(
	input  logic       clk,
	input  logic       adv,
	input  ctrl_word_t ctrl_s2,
	input  cfg_regs_t  cfg,
	output prod_word_t prod_s3
);

	logic signed [GainW:0] kp;
	logic signed [GainW:0] ki;
	logic signed [GainW:0] kd;

	// Unsigned gains as non-negative signed operands
	assign kp = $signed({1'b0, cfg.prop_gain});
	assign ki = $signed({1'b0, cfg.integ_gain});
	assign kd = $signed({1'b0, cfg.deriv_gain});

	// Registered products
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3.run           <= ctrl_s2.run;
			prod_s3.p_prod        <= kp * ctrl_s2.err;
			prod_s3.i_prod        <= ki * ctrl_s2.error_sum;
			prod_s3.d_prod        <= kd * ctrl_s2.diff;
			prod_s3.in_band       <= ctrl_s2.in_band;
			prod_s3.settled_event <= ctrl_s2.settled_event;
			prod_s3.active        <= ctrl_s2.active;
		end
	end

endmodule

FILE: design/ppls_out.sv
// Output stage of the PID loop: sum of products, floor shift, force clamp,
// and the output register of the result channel.
// Depends on ppls_pkg.
`timescale 1ns / 1ps

module ppls_out
	import ppls_pkg::*;
(
	input  logic         clk,
	input  logic         adv,
	input  prod_word_t   prod_s3,
	input  cfg_regs_t    cfg,
	output result_word_t result_s4
);

	logic signed [AccW-1:0]   acc;
	logic signed [ShW-1:0]    shifted;
	logic signed [ShW-1:0]    mf;
	logic signed [ShW-1:0]    neg_mf;
	logic signed [ForceW-1:0] force_val;

	// Sum and arithmetic shift (rounds toward minus infinity)
	always_comb begin
		acc     = AccW'(prod_s3.p_prod) + AccW'(prod_s3.i_prod) + AccW'(prod_s3.d_prod);
		shifted = acc[AccW-1:FracW];
	end

	// Force clamp; zero while the loop does not run
	always_comb begin
		mf     = $signed({{(ShW-LimW){1'b0}}, cfg.force_limit});
		neg_mf = -mf;
		if (!prod_s3.run) begin
			force_val = '0;
		end else if (shifted > mf) begin
			force_val = mf[ForceW-1:0];
		end else if (shifted < neg_mf) begin
			force_val = neg_mf[ForceW-1:0];
		end else begin
			force_val = shifted[ForceW-1:0];
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (adv) begin
			result_s4.force_res     <= force_val;
			result_s4.in_band       <= prod_s3.in_band;
			result_s4.settled_event <= prod_s3.settled_event;
			result_s4.active        <= prod_s3.active;
		end
	end

endmodule

FILE: design/pid_position_loop_settle.sv
// PID position loop for one joint, top level: register file, channel
// handshakes, and the control, product and output stages.
// Depends on ppls_pkg, ppls_ctrl, ppls_mult, ppls_out.
//
// Usage:
//   item channel (item_valid / item_stall / item): one control tick per word,
//   opcode tick, start or stop plus target and measured angle.
//   result channel (result_valid / result_stall / result): exactly one word
//   per item, in order: force, in-band flag, settled event, active flag.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register
//   writes, always ready; write only while no item is in flight.
// Result valid rises after the item has passed the input register, control
// stage, multiply stage and output register. Throughput is one item per
// cycle while the receiver does not stall a result; the loop state
// recurrence closes in the single control stage.
// When the receiver stalls a valid result, the whole pipe holds and
// item_stall rises in the same cycle; no words are lost or dropped.
// Reset clears the loop state, the pipe valid bits and the registers to
// their reset values (sum limit to its maximum, all others to zero).
`timescale 1ns / 1ps

module pid_position_loop_settle
	import ppls_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  item_word_t          item,
	output logic                result_valid,
	input  logic                result_stall,
	output result_word_t        result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	cfg_regs_t    cfg_q;
	item_word_t   item_s1;
	logic         vld_s1;
	logic         vld_s2;
	logic         vld_s3;
	logic         vld_s4;
	logic         adv;
	ctrl_word_t   ctrl_s2;
	prod_word_t   prod_s3;
	result_word_t result_s4;

	// Pipe moves unless a finished word is held by the receiver
	assign adv          = !(vld_s4 && result_stall);
	assign item_stall   = !adv;
	assign cfg_ready    = 1'b1;
	assign result_valid = vld_s4;
	assign result       = result_s4;

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain        <= '0;
			cfg_q.integ_gain       <= '0;
			cfg_q.deriv_gain       <= '0;
			cfg_q.error_sum_limit  <= SUM_LIMIT_RESET;
			cfg_q.force_limit      <= '0;
			cfg_q.settle_threshold <= '0;
			cfg_q.settle_ticks     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PROP_GAIN: begin
					cfg_q.prop_gain <= cfg_data[GainW-1:0];
				end
				REG_INTEG_GAIN: begin
					cfg_q.integ_gain <= cfg_data[GainW-1:0];
				end
				REG_DERIV_GAIN: begin
					cfg_q.deriv_gain <= cfg_data[GainW-1:0];
				end
				REG_SUM_LIMIT: begin
					cfg_q.error_sum_limit <= cfg_data[LimW-1:0];
				end
				REG_FORCE_LIMIT: begin
					cfg_q.force_limit <= cfg_data[LimW-1:0];
				end
				REG_SETTLE_THR: begin
					cfg_q.settle_threshold <= cfg_data[ThrW-1:0];
				end
				REG_SETTLE_TICKS: begin
					cfg_q.settle_ticks <= cfg_data[CntW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= item_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= item;
		end
	end

	ppls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.item_vld (vld_s1),
		.item_w   (item_s1),
		.cfg      (cfg_q),
		.ctrl_s2  (ctrl_s2)
	);

	ppls_mult u_mult (
		.clk     (clk),
		.adv     (adv),
		.ctrl_s2 (ctrl_s2),
		.cfg     (cfg_q),
		.prod_s3 (prod_s3)
	);

	ppls_out u_out (
		.clk       (clk),
		.adv       (adv),
		.prod_s3   (prod_s3),
		.cfg       (cfg_q),
		.result_s4 (result_s4)
	);

	// An idle loop drives no force
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.active) |-> (result.force_res == '0))
		else $error("nonzero force while loop idle");

	// In-band is only reported on a running tick
	a_band_active: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.in_band) |-> result.active)
		else $error("in-band flag without active loop");

endmodule

FILE: tb/tb_pid_position_loop_settle.sv
// Self-checking testbench for pid_position_loop_settle: directed corner words, then
// random moves (start, converging ticks, stop) under several register settings.
// Depends on ppls_pkg and the pid_position_loop_settle RTL.
`timescale 1ns / 1ps

module tb_pid_position_loop_settle;
	import ppls_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 8;
	localparam int DRAIN_CYCLES = 8;      // margin for the pipe to empty
	localparam int LONG_HOLD    = 80;     // receiver hold, long enough to back up the pipe
	localparam int IDLE_LIMIT   = 2000;   // cycles with no handshake at all
	localparam int WAIT_MAX     = 9;
	localparam int ANGLE_HI     = 524287;
	localparam int ANGLE_LO     = -524288;
	localparam int COUNT_SAT    = 65535;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                item_valid = 1'b0;
	logic                item_stall;
	item_word_t          item = '0;
	logic                result_valid;
	logic                result_stall;
	result_word_t        result;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	pid_position_loop_settle dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// Stimulus and expectation stores
	item_word_t   pending_items[$];
	result_word_t expected_results[$];

	// Register mirror and loop state of the predictor
	cfg_regs_t loop_cfg;
	longint    loop_sum      = 0;
	longint    loop_last_err = 0;
	int        loop_band_cnt = 0;
	bit        loop_pending  = 1'b0;
	bit        loop_running  = 1'b0;

	// Idle control
	int sender_gap_max     = 0;
	int receiver_stall_max = 0;
	int gap_left           = 0;
	int stall_left         = 0;
	logic random_stall     = 1'b0;
	logic hold_request     = 1'b0;
	int hold_cnt           = 0;

	// Bookkeeping
	int fail_count    = 0;
	int words_sent    = 0;
	int words_checked = 0;
	int events_seen   = 0;
	int band_seen     = 0;
	int moves_queued  = 0;
	int settings_used = 0;
	int idle_cycles   = 0;

	assign result_stall = random_stall | (hold_cnt != 0);

	function automatic longint clamp_sym(input longint v, input longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// One control tick of the loop: updates the state copy, returns the result word
	function automatic result_word_t predict_loop_output(input item_word_t w);
		longint err, acc, frc, mag;
		logic band, evt;
		result_word_t r;
		err  = longint'($signed(w.target_angle)) - longint'($signed(w.measured_angle));
		frc  = 0;
		band = 1'b0;
		evt  = 1'b0;
		if (w.opcode == OP_STOP) begin
			evt = loop_pending;
			loop_pending = 1'b0;
			loop_running = 1'b0;
		end else if (w.opcode == OP_START || (w.opcode == OP_TICK && loop_running)) begin
			// start ends the old move first, then runs a tick with zero derivative
			if (w.opcode == OP_START) begin
				evt = loop_pending;
				loop_sum = 0;
				loop_last_err = err;
				loop_band_cnt = 0;
				loop_pending = 1'b1;
				loop_running = 1'b1;
			end
			loop_sum = clamp_sym(loop_sum + err, longint'(loop_cfg.error_sum_limit));
			acc = longint'(loop_cfg.prop_gain) * err
				+ longint'(loop_cfg.integ_gain) * loop_sum
				+ longint'(loop_cfg.deriv_gain) * (err - loop_last_err);
			// arithmetic shift floors toward minus infinity
			frc = clamp_sym(acc >>> FracW, longint'(loop_cfg.force_limit));
			loop_last_err = err;
			mag = (err < 0) ? -err : err;
			band = (mag < longint'(loop_cfg.settle_threshold));
			if (band) begin
				if (loop_band_cnt < COUNT_SAT)
					loop_band_cnt++;
				if (loop_band_cnt >= int'(loop_cfg.settle_ticks) && loop_pending) begin
					evt = 1'b1;
					loop_pending = 1'b0;
				end
			end else begin
				loop_band_cnt = 0;
			end
		end
		r.force_res     = frc[ForceW-1:0];
		r.in_band       = band;
		r.settled_event = evt;
		r.active        = loop_running;
		return r;
	endfunction

	function automatic int draw_wait(input int max_wait);
		return (max_wait == 0) ? 0 : int'($urandom_range(0, max_wait));
	endfunction

	function automatic logic signed [AngleW-1:0] rand_angle();
		return AngleW'($urandom);
	endfunction

	function automatic logic signed [AngleW-1:0] sat_angle(input int v);
		if (v > ANGLE_HI)
			return AngleW'(ANGLE_HI);
		if (v < ANGLE_LO)
			return AngleW'(ANGLE_LO);
		return v[AngleW-1:0];
	endfunction

	function automatic cfg_regs_t rand_regs();
		cfg_regs_t c;
		c.prop_gain        = GainW'($urandom);
		c.integ_gain       = GainW'($urandom);
		c.deriv_gain       = GainW'($urandom);
		c.error_sum_limit  = LimW'($urandom);
		c.force_limit      = LimW'($urandom);
		c.settle_threshold = ThrW'($urandom_range(0, 4096));
		c.settle_ticks     = CntW'($urandom_range(0, 8));
		return c;
	endfunction

	task automatic push_item(input logic [1:0] op, input int tgt, input int meas);
		item_word_t w;
		w.opcode         = op;
		w.target_angle   = sat_angle(tgt);
		w.measured_angle = sat_angle(meas);
		pending_items.push_back(w);
	endtask

	// Register write; the mirror follows once the write is taken
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_PROP_GAIN:    loop_cfg.prop_gain        = val[GainW-1:0];
			REG_INTEG_GAIN:   loop_cfg.integ_gain       = val[GainW-1:0];
			REG_DERIV_GAIN:   loop_cfg.deriv_gain       = val[GainW-1:0];
			REG_SUM_LIMIT:    loop_cfg.error_sum_limit  = val[LimW-1:0];
			REG_FORCE_LIMIT:  loop_cfg.force_limit      = val[LimW-1:0];
			REG_SETTLE_THR:   loop_cfg.settle_threshold = val[ThrW-1:0];
			REG_SETTLE_TICKS: loop_cfg.settle_ticks     = val[CntW-1:0];
			default: ;
		endcase
	endtask

	task automatic set_loop_regs(input cfg_regs_t c);
		write_reg(REG_PROP_GAIN,    CfgDataW'(c.prop_gain));
		write_reg(REG_INTEG_GAIN,   CfgDataW'(c.integ_gain));
		write_reg(REG_DERIV_GAIN,   CfgDataW'(c.deriv_gain));
		write_reg(REG_SUM_LIMIT,    CfgDataW'(c.error_sum_limit));
		write_reg(REG_FORCE_LIMIT,  CfgDataW'(c.force_limit));
		write_reg(REG_SETTLE_THR,   CfgDataW'(c.settle_threshold));
		write_reg(REG_SETTLE_TICKS, CfgDataW'(c.settle_ticks));
		settings_used++;
		@(negedge clk);
	endtask

	// Sender holds back until every expected word is back, then the pipe gets time to empty
	task automatic wait_until_drained();
		do @(negedge clk);
		while (pending_items.size() != 0 || item_valid || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Random moves: start, ticks that mostly converge on the target, usually a stop;
	// stray words outside moves and the unused code mixed in
	task automatic queue_moves(input int n_words);
		int queued, len, err, tgt, stray;
		logic [1:0] op;
		queued = 0;
		while (queued < n_words) begin
			if ($urandom_range(0, 15) == 0) begin
				stray = $urandom_range(0, 2);
				op = (stray == 0) ? OP_TICK : (stray == 1) ? OP_STOP : OP_UNUSED;
				push_item(op, int'(rand_angle()), int'(rand_angle()));
			end else begin
				tgt = int'(rand_angle());
				if ($urandom_range(0, 3) == 0)
					err = tgt - int'(rand_angle());
				else
					err = int'($urandom_range(0, 8000)) - 4000;
				push_item(OP_START, tgt, tgt - err);
				len = $urandom_range(2, 30);
				for (int k = 0; k < len; k++) begin
					if ($urandom_range(0, 19) == 0)
						err = int'(rand_angle());
					else
						err = err / 2 + int'($urandom_range(0, 6)) - 3;
					if ($urandom_range(0, 24) == 0)
						push_item(OP_UNUSED, int'(rand_angle()), int'(rand_angle()));
					push_item(OP_TICK, tgt, tgt - err);
				end
				queued += len + 1;
				if ($urandom_range(0, 3) != 0) begin
					push_item(OP_STOP, int'(rand_angle()), int'(rand_angle()));
					queued++;
				end
				moves_queued++;
			end
		end
	endtask

	task automatic run_random_phase(input cfg_regs_t c, input int gap_max, input int stall_max,
			input int n_words, input bit long_hold);
		set_loop_regs(c);
		sender_gap_max     = gap_max;
		receiver_stall_max = stall_max;
		queue_moves(n_words);
		if (long_hold) begin
			@(posedge clk);
			hold_request <= 1'b1;
			@(posedge clk);
			hold_request <= 1'b0;
		end
		wait_until_drained();
	endtask

	// Item driver: offers queued words, each followed by a drawn gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item       <= '0;
			gap_left   <= 0;
		end else begin
			if (item_valid && !item_stall) begin
				expected_results.push_back(predict_loop_output(item));
				words_sent++;
			end
			if (!item_valid || !item_stall) begin
				if (gap_left != 0) begin
					item_valid <= 1'b0;
					gap_left   <= gap_left - 1;
				end else if (pending_items.size() != 0) begin
					item       <= pending_items.pop_front();
					item_valid <= 1'b1;
					gap_left   <= draw_wait(sender_gap_max);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares each taken word with the oldest expectation
	always @(posedge clk or negedge arst_n) begin : result_monitor
		int n;
		result_word_t want;
		if (!arst_n) begin
			random_stall <= 1'b0;
			stall_left   <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				words_checked++;
				if (expected_results.size() == 0) begin
					$error("result word with no expectation waiting");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (result.force_res !== want.force_res) begin
						$error("force_res: expected %0d, actual %0d", want.force_res,
							result.force_res);
						fail_count++;
					end
					if (result.in_band !== want.in_band) begin
						$error("in_band: expected %0b, actual %0b", want.in_band, result.in_band);
						fail_count++;
					end
					if (result.settled_event !== want.settled_event) begin
						$error("settled_event: expected %0b, actual %0b", want.settled_event,
							result.settled_event);
						fail_count++;
					end
					if (result.active !== want.active) begin
						$error("active: expected %0b, actual %0b", want.active, result.active);
						fail_count++;
					end
					events_seen += want.settled_event;
					band_seen   += want.in_band;
				end
			end
			// drawn stall after each taken word
			if (stall_left != 0) begin
				stall_left   <= stall_left - 1;
				random_stall <= (stall_left != 1);
			end else if (result_valid && !result_stall) begin
				n = draw_wait(receiver_stall_max);
				stall_left   <= n;
				random_stall <= (n != 0);
			end
		end
	end

	// Long receiver hold, counted here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_cnt <= 0;
		else if (hold_request)
			hold_cnt <= LONG_HOLD;
		else if (hold_cnt != 0)
			hold_cnt <= hold_cnt - 1;
	end

	// Watchdog on handshake activity
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)
					|| (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		cfg_regs_t c;
		loop_cfg = '0;
		loop_cfg.error_sum_limit = SUM_LIMIT_RESET;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: all gains and bounds at their maximum, zero settle time
		c.prop_gain        = '1;
		c.integ_gain       = '1;
		c.deriv_gain       = '1;
		c.error_sum_limit  = '1;
		c.force_limit      = '1;
		c.settle_threshold = '1;
		c.settle_ticks     = '0;
		set_loop_regs(c);
		sender_gap_max     = WAIT_MAX;
		receiver_stall_max = WAIT_MAX;
		push_item(OP_TICK, ANGLE_HI, ANGLE_LO);     // tick while idle
		push_item(OP_STOP, ANGLE_LO, ANGLE_HI);     // stop while idle, nothing pending
		push_item(OP_UNUSED, ANGLE_HI, ANGLE_HI);
		push_item(OP_START, ANGLE_HI, ANGLE_LO);    // largest error, just outside the band
		push_item(OP_TICK, ANGLE_LO, ANGLE_HI);     // most negative error and difference
		push_item(OP_TICK, 0, 0);                   // in band, settles at once
		push_item(OP_TICK, 5, 5);                   // event does not repeat
		push_item(OP_UNUSED, 1, 2);                 // ignored while running
		push_item(OP_START, 0, 0);                  // restart, settles on the first tick
		push_item(OP_START, ANGLE_HI, ANGLE_LO);    // restart out of band, event pending
		push_item(OP_STOP, 0, 0);                   // stop fires the pending event
		push_item(OP_STOP, 0, 0);
		wait_until_drained();

		// Directed: tight sum bound, force bound and band
		c.prop_gain        = 24'd1;
		c.integ_gain       = 24'h01_0000;
		c.deriv_gain       = 24'h00_8000;
		c.error_sum_limit  = 31'd1000;
		c.force_limit      = 31'd1000000;
		c.settle_threshold = 20'd16;
		c.settle_ticks     = 16'd3;
		set_loop_regs(c);
		push_item(OP_START, 5000, 0);               // sum clamps high
		push_item(OP_TICK, 0, 3000);                // sum clamps low
		push_item(OP_TICK, 0, 1);                   // positive force rounds down
		push_item(OP_TICK, 2, 0);
		push_item(OP_TICK, -3, 0);                  // third in-band tick settles
		push_item(OP_TICK, 20, 0);                  // out of band, count clears
		push_item(OP_TICK, 16, 0);                  // error equal to threshold is out
		push_item(OP_START, 15, 0);
		push_item(OP_START, 0, 0);                  // start while pending fires old event
		push_item(OP_STOP, 0, 0);
		wait_until_drained();

		// Random moves over a spread of settings
		c.prop_gain        = 24'h02_0000;
		c.integ_gain       = 24'h00_0800;
		c.deriv_gain       = 24'h01_0000;
		c.error_sum_limit  = 31'd200000;
		c.force_limit      = 31'h0040_0000;
		c.settle_threshold = 20'd256;
		c.settle_ticks     = 16'd4;
		run_random_phase(c, WAIT_MAX, WAIT_MAX, 250, 1'b0);

		c.prop_gain        = '1;
		c.integ_gain       = '1;
		c.deriv_gain       = '1;
		c.error_sum_limit  = '1;
		c.force_limit      = '1;
		c.settle_threshold = '1;
		c.settle_ticks     = '1;
		run_random_phase(c, 0, 0, 250, 1'b0);

		run_random_phase('0, WAIT_MAX, 0, 100, 1'b0);
		run_random_phase(rand_regs(), 0, WAIT_MAX, 250, 1'b1);
		run_random_phase(rand_regs(), WAIT_MAX, WAIT_MAX, 250, 1'b0);

		$display("Run covered %0d words in %0d random moves under %0d register settings,",
			words_sent, moves_queued, settings_used);
		$display("with %0d settled events and %0d in-band ticks checked.", events_seen, band_seen);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
